// ===== src/lei_pkg.sv =====
// Package for the landmark edge information block.
// Holds shared constants, the CORDIC angle table and a saturating helper.
// No dependencies.
package lei_pkg;

  localparam int FRAC_BITS_DEF     = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_LEN          = 24;
  localparam int MUL_LAT           = 4;

  localparam logic [31:0] CORDIC_GAIN = 32'd652032874;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_RATE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BEARING_STD = 2'd1;

  localparam logic [15:0] RANGE_RATE_RESET  = 16'd9175;
  localparam logic [15:0] BEARING_STD_RESET = 16'd3277;

  // atan(2^-i) with 2^32 units per turn.
  localparam logic [31:0] ATAN_TBL [ATAN_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  function automatic logic signed [63:0] sat_add64(logic signed [63:0] a,
                                                   logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      sat_add64 = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      sat_add64 = s[63:0];
    end
  endfunction

endpackage

// ===== src/lei_if.sv =====
// Valid/ready channel interfaces for the landmark edge information block.
// Carries the observation item in and the information item out; no dependencies.
interface lei_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic        [15:0] pose_heading;
  logic        [30:0] meas_range;
  logic        [15:0] meas_bearing;
  modport source(output valid, pose_x, pose_y, pose_heading, meas_range, meas_bearing,
                 input ready);
  modport sink(input valid, pose_x, pose_y, pose_heading, meas_range, meas_bearing,
               output ready);
endinterface

interface lei_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] landmark_x;
  logic signed [31:0] landmark_y;
  logic signed [63:0] info_xx;
  logic signed [63:0] info_xy;
  logic signed [63:0] info_yy;
  logic signed [63:0] info_vec_x;
  logic signed [63:0] info_vec_y;
  modport source(output valid, landmark_x, landmark_y, info_xx, info_xy, info_yy,
                 info_vec_x, info_vec_y, input ready);
  modport sink(input valid, landmark_x, landmark_y, info_xx, info_xy, info_yy,
               info_vec_x, info_vec_y, output ready);
endinterface

// ===== src/lei_mul.sv =====
// Pipelined signed multiply with round-half-away shift and 64-bit saturation.
// Splits operands into 32-bit chunks and registers the partial products.
module lei_mul #(
  parameter int AW = 32,
  parameter int BW = 32,
  parameter int SH = 0
) (
  input  logic                 clk_i,
  input  logic                 ce_i,
  input  logic signed [AW-1:0] a_i,
  input  logic signed [BW-1:0] b_i,
  output logic signed [63:0]   p_o
);
  localparam int NA = (AW + 31) / 32;
  localparam int NB = (BW + 31) / 32;
  localparam int PW = 32 * (NA + NB);
  localparam int HS = (SH > 0) ? SH - 1 : 0;

  logic [AW-1:0]   abs_a;
  logic [BW-1:0]   abs_b;
  logic [NA*32-1:0] ua_q;
  logic [NB*32-1:0] ub_q;
  logic            neg1_q, neg2_q, neg3_q;
  logic [63:0]     pp_q [NA][NB];
  logic [PW-1:0]   prod_d, prod_q;
  logic [PW:0]     rnd, quo;
  logic [63:0]     lim, mag;

  assign abs_a = a_i[AW-1] ? (~a_i + 1'b1) : a_i;
  assign abs_b = b_i[BW-1] ? (~b_i + 1'b1) : b_i;

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      ua_q   <= (NA*32)'(abs_a);
      ub_q   <= (NB*32)'(abs_b);
      neg1_q <= a_i[AW-1] ^ b_i[BW-1];
      neg2_q <= neg1_q;
      neg3_q <= neg2_q;
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_q[i][j] <= 64'(ua_q[32*i +: 32]) * 64'(ub_q[32*j +: 32]);
        end
      end
      prod_q <= prod_d;
    end
  end

  always_comb begin
    prod_d = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        prod_d = prod_d + (PW'(pp_q[i][j]) << (32 * (i + j)));
      end
    end
  end

  // Round half away from zero on the magnitude, then clamp and restore the sign.
  always_comb begin
    rnd = {1'b0, prod_q};
    if (SH > 0) begin
      rnd = rnd + ((PW+1)'(1) << HS);
    end
    quo = rnd >> SH;
    lim = neg3_q ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    mag = (quo > (PW+1)'(lim)) ? lim : quo[63:0];
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      p_o <= neg3_q ? (~mag + 1'b1) : mag;
    end
  end
endmodule

// ===== src/lei_delay.sv =====
// Clock-enabled delay line that keeps side data aligned with the CORDIC stages and the multipliers.
// No dependencies.
module lei_delay #(
  parameter int W = 8,
  parameter int D = 1
) (
  input  logic         clk_i,
  input  logic         ce_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);
  logic [W-1:0] sr_q [D];

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      sr_q[0] <= d_i;
      for (int k = 1; k < D; k++) begin
        sr_q[k] <= sr_q[k-1];
      end
    end
  end

  assign q_o = sr_q[D-1];
endmodule

// ===== src/landmark_edge_information.sv =====
// Landmark edge information: CORDIC, landmark position, Omega and xi, fully pipelined.
// Takes one item per cycle while the output is not stalled.
// The CORDIC stages and four levels of pipelined multipliers (A to D) set the depth.
// A stalled output freezes the whole pipeline; no item is lost or repeated.
// Reset is asynchronous, active low; it empties the pipeline and restores the configuration registers.
// Depends on lei_pkg, lei_if, lei_mul and lei_delay.
module landmark_edge_information #(
  parameter int FRAC_BITS     = lei_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STAGES = lei_pkg::CORDIC_STAGES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lei_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [15:0]                   cfg_data_i,
  lei_in_if.sink                        in_i,
  lei_out_if.source                     out_o
);
  localparam int XW  = 34;
  localparam int CW  = FRAC_BITS + 2;
  localparam int CCW = 2 * CW;
  localparam int RS  = 30 - FRAC_BITS;
  localparam int L   = lei_pkg::MUL_LAT;
  localparam int TOT = CORDIC_STAGES + 20;

  logic           ce, in_acc;
  logic [TOT-1:0] valid_q;

  assign ce         = !valid_q[TOT-1] || out_o.ready;
  assign in_acc     = in_i.valid && ce;
  assign in_i.ready = ce;
  assign out_o.valid = valid_q[TOT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ce) begin
      valid_q <= {valid_q[TOT-2:0], in_acc};
    end
  end

  // Configuration registers, their squares and the difference of the squares.
  logic [15:0]        rate_q, bstd_q;
  logic [31:0]        ra_q, rb_q;
  logic signed [32:0] rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= lei_pkg::RANGE_RATE_RESET;
      bstd_q <= lei_pkg::BEARING_STD_RESET;
      ra_q   <= '0;
      rb_q   <= '0;
      rd_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          lei_pkg::CFG_RANGE_RATE:  rate_q <= cfg_data_i;
          lei_pkg::CFG_BEARING_STD: bstd_q <= cfg_data_i;
          default: ;
        endcase
      end
      ra_q <= 32'(rate_q) * 32'(rate_q);
      rb_q <= 32'(bstd_q) * 32'(bstd_q);
      rd_q <= $signed({1'b0, ra_q}) - $signed({1'b0, rb_q});
    end
  end

  // Entry stage: angle sum and fold into the right half plane.
  logic [15:0] ang;
  logic [31:0] a32, af;
  logic        flip;
  assign ang  = in_i.pose_heading + in_i.meas_bearing;
  assign a32  = {ang, 16'd0};
  assign flip = a32[31] ^ a32[30];
  assign af   = {a32[31] ^ flip, a32[30:0]};

  logic signed [XW-1:0] x_q [CORDIC_STAGES+1];
  logic signed [XW-1:0] y_q [CORDIC_STAGES+1];
  logic signed [XW-1:0] z_q [CORDIC_STAGES+1];
  logic [95:0]          side0_q, side_c;

  always_ff @(posedge clk_i) begin
    if (ce) begin
      x_q[0]  <= XW'(lei_pkg::CORDIC_GAIN);
      y_q[0]  <= '0;
      z_q[0]  <= XW'($signed(af));
      side0_q <= {in_i.pose_x, in_i.pose_y, in_i.meas_range, flip};
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    logic signed [XW-1:0] at;
    assign at = $signed({2'b00, lei_pkg::ATAN_TBL[i]});
    always_ff @(posedge clk_i) begin
      if (ce) begin
        if (!z_q[i][XW-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - at;
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + at;
        end
      end
    end
  end

  lei_delay #(.W(96), .D(CORDIC_STAGES)) u_dl_side (
    .clk_i, .ce_i(ce), .d_i(side0_q), .q_o(side_c)
  );

  function automatic logic signed [CW-1:0] rnd_q30(logic signed [XW-1:0] v, logic neg_in);
    logic signed [XW-1:0] w;
    logic [XW-1:0]        mag;
    logic [XW-1:0]        q;
    w   = neg_in ? -v : v;
    mag = w[XW-1] ? (~w + 1'b1) : w;
    q   = (mag + (XW'(1) << (RS - 1))) >> RS;
    rnd_q30 = w[XW-1] ? -$signed(q[CW-1:0]) : $signed(q[CW-1:0]);
  endfunction

  // Trig stage.
  logic signed [CW-1:0] c_q, s_q;
  logic signed [31:0]   px_q, py_q;
  logic [30:0]          r_q;

  always_ff @(posedge clk_i) begin
    if (ce) begin
      c_q  <= rnd_q30(x_q[CORDIC_STAGES], side_c[0]);
      s_q  <= rnd_q30(y_q[CORDIC_STAGES], side_c[0]);
      px_q <= side_c[95:64];
      py_q <= side_c[63:32];
      r_q  <= side_c[31:1];
    end
  end

  // Level A: offsets, squares and cross product of the direction, square of the range.
  logic signed [31:0] r_s;
  logic signed [63:0] mcx, mcy, cc_p, ss_p, cs_p, r2_p;
  logic [63:0]        pxy_d;
  assign r_s = $signed({1'b0, r_q});

  lei_mul #(.AW(32), .BW(CW), .SH(FRAC_BITS)) u_mcx (
    .clk_i, .ce_i(ce), .a_i(r_s), .b_i(c_q), .p_o(mcx));
  lei_mul #(.AW(32), .BW(CW), .SH(FRAC_BITS)) u_mcy (
    .clk_i, .ce_i(ce), .a_i(r_s), .b_i(s_q), .p_o(mcy));
  lei_mul #(.AW(CW), .BW(CW), .SH(0)) u_cc (
    .clk_i, .ce_i(ce), .a_i(c_q), .b_i(c_q), .p_o(cc_p));
  lei_mul #(.AW(CW), .BW(CW), .SH(0)) u_ss (
    .clk_i, .ce_i(ce), .a_i(s_q), .b_i(s_q), .p_o(ss_p));
  lei_mul #(.AW(CW), .BW(CW), .SH(0)) u_cs (
    .clk_i, .ce_i(ce), .a_i(c_q), .b_i(s_q), .p_o(cs_p));
  lei_mul #(.AW(32), .BW(32), .SH(0)) u_r2 (
    .clk_i, .ce_i(ce), .a_i(r_s), .b_i(r_s), .p_o(r2_p));
  lei_delay #(.W(64), .D(L)) u_dl_pxy (
    .clk_i, .ce_i(ce), .d_i({px_q, py_q}), .q_o(pxy_d));

  // Landmark position, saturated to 32 bits.
  function automatic logic signed [31:0] sat32(logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (v < -66'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  logic signed [31:0] mx_q, my_q;
  always_ff @(posedge clk_i) begin
    if (ce) begin
      mx_q <= sat32(66'($signed(pxy_d[63:32])) + 66'(mcx));
      my_q <= sat32(66'($signed(pxy_d[31:0])) + 66'(mcy));
    end
  end

  // Level B: inner terms of Omega.
  logic signed [CCW-1:0] cc_w, ss_w, cs_w;
  logic signed [32:0]    ra_s, rb_s;
  logic signed [63:0]    tx1, tx2, ty1, ty2, txy;
  assign cc_w = cc_p[CCW-1:0];
  assign ss_w = ss_p[CCW-1:0];
  assign cs_w = cs_p[CCW-1:0];
  assign ra_s = $signed({1'b0, ra_q});
  assign rb_s = $signed({1'b0, rb_q});

  lei_mul #(.AW(CCW), .BW(33), .SH(2*FRAC_BITS)) u_tx1 (
    .clk_i, .ce_i(ce), .a_i(cc_w), .b_i(ra_s), .p_o(tx1));
  lei_mul #(.AW(CCW), .BW(33), .SH(2*FRAC_BITS)) u_tx2 (
    .clk_i, .ce_i(ce), .a_i(ss_w), .b_i(rb_s), .p_o(tx2));
  lei_mul #(.AW(CCW), .BW(33), .SH(2*FRAC_BITS)) u_ty1 (
    .clk_i, .ce_i(ce), .a_i(ss_w), .b_i(ra_s), .p_o(ty1));
  lei_mul #(.AW(CCW), .BW(33), .SH(2*FRAC_BITS)) u_ty2 (
    .clk_i, .ce_i(ce), .a_i(cc_w), .b_i(rb_s), .p_o(ty2));
  lei_mul #(.AW(CCW), .BW(33), .SH(2*FRAC_BITS)) u_txy (
    .clk_i, .ce_i(ce), .a_i(cs_w), .b_i(rd_q), .p_o(txy));

  logic signed [63:0] gxx_q, gxy_q, gyy_q;
  always_ff @(posedge clk_i) begin
    if (ce) begin
      gxx_q <= lei_pkg::sat_add64(tx1, tx2);
      gyy_q <= lei_pkg::sat_add64(ty1, ty2);
      gxy_q <= txy;
    end
  end

  logic [63:0] r2_d, mx8, mx12;
  lei_delay #(.W(64), .D(L+1)) u_dl_r2 (
    .clk_i, .ce_i(ce), .d_i(r2_p), .q_o(r2_d));
  lei_delay #(.W(64), .D(2*L)) u_dl_m8 (
    .clk_i, .ce_i(ce), .d_i({mx_q, my_q}), .q_o(mx8));
  lei_delay #(.W(64), .D(L)) u_dl_m12 (
    .clk_i, .ce_i(ce), .d_i(mx8), .q_o(mx12));

  // Level C: Omega entries.
  logic signed [63:0] oxx, oxy, oyy;
  logic [191:0]       o_d;
  lei_mul #(.AW(64), .BW(64), .SH(32)) u_oxx (
    .clk_i, .ce_i(ce), .a_i($signed(r2_d)), .b_i(gxx_q), .p_o(oxx));
  lei_mul #(.AW(64), .BW(64), .SH(32)) u_oxy (
    .clk_i, .ce_i(ce), .a_i($signed(r2_d)), .b_i(gxy_q), .p_o(oxy));
  lei_mul #(.AW(64), .BW(64), .SH(32)) u_oyy (
    .clk_i, .ce_i(ce), .a_i($signed(r2_d)), .b_i(gyy_q), .p_o(oyy));
  lei_delay #(.W(192), .D(L)) u_dl_o (
    .clk_i, .ce_i(ce), .d_i({oxx, oxy, oyy}), .q_o(o_d));

  // Level D: information vector terms.
  logic signed [31:0] mx8_s, my8_s;
  logic signed [63:0] vxa, vxb, vya, vyb;
  assign mx8_s = $signed(mx8[63:32]);
  assign my8_s = $signed(mx8[31:0]);
  lei_mul #(.AW(64), .BW(32), .SH(16)) u_vxa (
    .clk_i, .ce_i(ce), .a_i(oxx), .b_i(mx8_s), .p_o(vxa));
  lei_mul #(.AW(64), .BW(32), .SH(16)) u_vxb (
    .clk_i, .ce_i(ce), .a_i(oxy), .b_i(my8_s), .p_o(vxb));
  lei_mul #(.AW(64), .BW(32), .SH(16)) u_vya (
    .clk_i, .ce_i(ce), .a_i(oxy), .b_i(mx8_s), .p_o(vya));
  lei_mul #(.AW(64), .BW(32), .SH(16)) u_vyb (
    .clk_i, .ce_i(ce), .a_i(oyy), .b_i(my8_s), .p_o(vyb));

  // Output register.
  always_ff @(posedge clk_i) begin
    if (ce) begin
      out_o.landmark_x <= $signed(mx12[63:32]);
      out_o.landmark_y <= $signed(mx12[31:0]);
      out_o.info_xx    <= $signed(o_d[191:128]);
      out_o.info_xy    <= $signed(o_d[127:64]);
      out_o.info_yy    <= $signed(o_d[63:0]);
      out_o.info_vec_x <= lei_pkg::sat_add64(vxa, vxb);
      out_o.info_vec_y <= lei_pkg::sat_add64(vya, vyb);
    end
  end
endmodule

// ===== src/lei_checker.sv =====
// Port-level checker for landmark_edge_information, attached with a bind.
// Depends on the top level's clock, reset and interface ports only.
module lei_props (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] landmark_x,
  input logic [63:0] info_xx,
  input logic [63:0] info_yy
);
  a_ready_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow the output stall");

  a_diag_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (!info_xx[63] && !info_yy[63]))
    else $error("diagonal information entry is negative");

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result item dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> ($stable(landmark_x) && $stable(info_xx)))
    else $error("result item changed while stalled");
endmodule

bind landmark_edge_information lei_props u_lei_props (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready   (in_i.ready),
  .out_valid  (out_o.valid),
  .out_ready  (out_o.ready),
  .landmark_x (out_o.landmark_x),
  .info_xx    (out_o.info_xx),
  .info_yy    (out_o.info_yy)
);
